/* design/egcd_pkg.sv */
// Package for the binary extended GCD block.
// Holds the field width, the datapath operation codes and the control
// and status structs shared by the sequencer and the datapath.
package egcd_pkg;

    localparam int FIELD_BITS = 64;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SPECIAL,
        OP_INIT,
        OP_ZB,
        OP_STRIP,
        OP_STEP,
        OP_FIN,
        OP_PREP,
        OP_HALF,
        OP_CORR,
        OP_SIGN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic uv_even;
        logic u_even;
        logic v_even;
        logic u_eq_v;
        logic shift_zero;
    } t_stat;

endpackage

/* design/egcd_if.sv */
// Handshake channel interfaces for the binary extended GCD block.
// Depends on egcd_pkg for the field width.
interface egcd_in_if;
    logic valid;
    logic ready;
    logic signed [egcd_pkg::FIELD_BITS-1:0] first_operand;
    logic signed [egcd_pkg::FIELD_BITS-1:0] second_operand;

    modport source (output valid, output first_operand, output second_operand, input ready);
    modport sink (input valid, input first_operand, input second_operand, output ready);
endinterface

interface egcd_out_if;
    logic valid;
    logic ready;
    logic signed [egcd_pkg::FIELD_BITS-1:0] divisor;
    logic signed [egcd_pkg::FIELD_BITS-1:0] coef_first;
    logic signed [egcd_pkg::FIELD_BITS-1:0] coef_second;

    modport source (output valid, output divisor, output coef_first, output coef_second,
                    input ready);
    modport sink (input valid, input divisor, input coef_first, input coef_second,
                  output ready);
endinterface

/* design/egcd_dp.sv */
// Datapath of the binary extended GCD block: operand, cofactor and result
// registers with the shared subtract, strip and halving logic.
// Depends on egcd_pkg for the operation codes and the status struct.
module egcd_dp #(
    parameter int WORD_BITS = 64
) (
    input  logic                                   i_clk,
    input  egcd_pkg::t_ctrl                        i_ctrl,
    input  logic signed [egcd_pkg::FIELD_BITS-1:0] i_first_operand,
    input  logic signed [egcd_pkg::FIELD_BITS-1:0] i_second_operand,
    output egcd_pkg::t_stat                        o_stat,
    output logic signed [egcd_pkg::FIELD_BITS-1:0] o_divisor,
    output logic signed [egcd_pkg::FIELD_BITS-1:0] o_coef_first,
    output logic signed [egcd_pkg::FIELD_BITS-1:0] o_coef_second
);
    import egcd_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int ZW = $clog2(W);
    localparam int CW = $clog2(2 * W);

    logic [W-1:0]  r_a, r_b;
    logic [W-1:0]  r_u, r_v;
    logic [W-1:0]  r_s0, r_t0, r_s1, r_t1;
    logic [W-1:0]  r_ug, r_vg, r_ugh, r_vgh;
    logic [ZW-1:0] r_zb;
    logic [CW-1:0] r_shift;
    logic [W-1:0]  r_g, r_sr, r_tr;

    logic [W:0]    w_diff;
    logic          w_u_ge;
    logic          w_m;
    logic          w_corr;
    logic [W-1:0]  w_s0_dbl, w_t0_dbl;

    assign w_diff   = {1'b0, r_u} - {1'b0, r_v};
    assign w_u_ge   = !w_diff[W];
    assign w_m      = r_s0[0] | r_t0[0];
    assign w_s0_dbl = {r_s0[W-2:0], 1'b0};
    assign w_t0_dbl = {r_t0[W-2:0], 1'b0};
    assign w_corr   = ((r_s0 > W'(1)) && (w_s0_dbl >= r_vg)) ||
                      ((r_t0 > W'(1)) && (w_t0_dbl >= r_ug));

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                r_a <= i_first_operand[W-1:0];
                r_b <= i_second_operand[W-1:0];
            end
            OP_SPECIAL: begin
                if (r_a == '0) begin
                    r_g  <= r_b;
                    r_sr <= '0;
                    r_tr <= W'(1);
                end else begin
                    r_g  <= r_a;
                    r_sr <= W'(1);
                    r_tr <= '0;
                end
            end
            OP_INIT: begin
                r_u     <= r_a[W-1] ? W'(0) - r_a : r_a;
                r_v     <= r_b[W-1] ? W'(0) - r_b : r_b;
                r_s0    <= W'(1);
                r_t0    <= '0;
                r_s1    <= '0;
                r_t1    <= W'(1);
                r_zb    <= '0;
                r_shift <= '0;
            end
            OP_ZB: begin
                r_u  <= r_u >> 1;
                r_v  <= r_v >> 1;
                r_zb <= r_zb + ZW'(1);
            end
            OP_STRIP: begin
                if (!r_u[0]) begin
                    r_u  <= r_u >> 1;
                    r_t1 <= r_t1 << 1;
                    r_s1 <= r_s1 << 1;
                end else begin
                    r_v  <= r_v >> 1;
                    r_t0 <= r_t0 << 1;
                    r_s0 <= r_s0 << 1;
                end
                r_shift <= r_shift + CW'(1);
            end
            OP_STEP: begin
                if (w_u_ge) begin
                    r_u  <= w_diff[W-1:0];
                    r_t0 <= r_t0 + r_t1;
                    r_s0 <= r_s0 + r_s1;
                end else begin
                    r_v  <= r_v - r_u;
                    r_t1 <= r_t1 + r_t0;
                    r_s1 <= r_s1 + r_s0;
                end
            end
            OP_FIN: begin
                r_ug <= r_t0 + r_t1;
                r_vg <= r_s0 + r_s1;
            end
            OP_PREP: begin
                r_ugh <= (r_ug >> 1) + W'(r_ug[0]);
                r_vgh <= (r_vg >> 1) + W'(r_vg[0]);
            end
            OP_HALF: begin
                r_s0    <= (r_s0 >> 1) + (w_m ? r_vgh : '0);
                r_t0    <= (r_t0 >> 1) + (w_m ? r_ugh : '0);
                r_shift <= r_shift - CW'(1);
            end
            OP_CORR: begin
                if (w_corr) begin
                    r_s0 <= r_s0 - r_vg;
                    r_t0 <= r_t0 - r_ug;
                end
            end
            OP_SIGN: begin
                r_g  <= r_u << r_zb;
                r_sr <= r_a[W-1] ? W'(0) - r_s0 : r_s0;
                r_tr <= r_b[W-1] ? r_t0 : W'(0) - r_t0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.a_zero     = (r_a == '0);
        o_stat.b_zero     = (r_b == '0);
        o_stat.uv_even    = !(r_u[0] | r_v[0]);
        o_stat.u_even     = !r_u[0];
        o_stat.v_even     = !r_v[0];
        o_stat.u_eq_v     = (r_u == r_v);
        o_stat.shift_zero = (r_shift == '0);
    end

    assign o_divisor     = FIELD_BITS'($signed(r_g));
    assign o_coef_first  = FIELD_BITS'($signed(r_sr));
    assign o_coef_second = FIELD_BITS'($signed(r_tr));

endmodule

/* design/egcd_seq.sv */
// Sequencer of the binary extended GCD block: walks the datapath through
// setup, subtract-and-strip, halving, correction and sign restore, and owns the handshakes.
// Depends on egcd_pkg for the control and status structs.
module egcd_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  egcd_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output egcd_pkg::t_ctrl o_ctrl
);
    import egcd_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_INIT  = 10'b00_0000_0010,
        S_ZB    = 10'b00_0000_0100,
        S_STRIP = 10'b00_0000_1000,
        S_STEP  = 10'b00_0001_0000,
        S_PREP  = 10'b00_0010_0000,
        S_HALF  = 10'b00_0100_0000,
        S_CORR  = 10'b00_1000_0000,
        S_SIGN  = 10'b01_0000_0000,
        S_SPARE = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctrl.op   = OP_HOLD;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = OP_LOAD;
                    n_state   = S_INIT;
                end
            end
            S_INIT: begin
                if (i_stat.a_zero || i_stat.b_zero) begin
                    if (w_out_free) begin
                        o_ctrl.op   = OP_SPECIAL;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    o_ctrl.op = OP_INIT;
                    n_state   = S_ZB;
                end
            end
            S_ZB: begin
                if (i_stat.uv_even) begin
                    o_ctrl.op = OP_ZB;
                end else begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (i_stat.u_even || i_stat.v_even) begin
                    o_ctrl.op = OP_STRIP;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_stat.u_eq_v) begin
                    o_ctrl.op = OP_FIN;
                    n_state   = S_PREP;
                end else begin
                    o_ctrl.op = OP_STEP;
                    n_state   = S_STRIP;
                end
            end
            S_PREP: begin
                o_ctrl.op = OP_PREP;
                n_state   = S_HALF;
            end
            S_HALF: begin
                if (i_stat.shift_zero) begin
                    n_state = S_CORR;
                end else begin
                    o_ctrl.op = OP_HALF;
                end
            end
            S_CORR: begin
                o_ctrl.op = OP_CORR;
                n_state   = S_SIGN;
            end
            S_SIGN: begin
                if (w_out_free) begin
                    o_ctrl.op   = OP_SIGN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_step_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> !i_stat.u_even && !i_stat.v_even)
        else $error("Subtract step entered with an even operand.");

    a_strip_one_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STRIP |-> !i_stat.uv_even)
        else $error("Both operands even after the shared power of two was removed.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_INIT || r_state == S_SIGN))
        else $error("Result beat raised outside a result-producing state.");
`endif

endmodule

/* design/extended_gcd_binary_64.sv */
// Binary extended GCD: each input beat carries signed a and b, and each output beat returns
// g, s and t with g = s*a + t*b modulo 2^WORD_BITS, sign-extended to 64 bits; a zero a gives
// (b, 0, 1) and a zero b gives (a, 1, 0). One item is worked at a time, one bit of shift or
// one subtract per cycle; the work is set by the subtract rounds and the one-bit strip and
// halving loops of the shared datapath. A result that cannot leave waits for the sink. A
// finished result waits in the output register while the next item is already accepted.
module extended_gcd_binary_64 #(
    parameter int WORD_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    egcd_in_if.sink    i_in,
    egcd_out_if.source o_res
);
    import egcd_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    egcd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_ctrl      (w_ctrl)
    );

    egcd_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_ctrl           (w_ctrl),
        .i_first_operand  (i_in.first_operand),
        .i_second_operand (i_in.second_operand),
        .o_stat           (w_stat),
        .o_divisor        (o_res.divisor),
        .o_coef_first     (o_res.coef_first),
        .o_coef_second    (o_res.coef_second)
    );

    assign i_in.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;

endmodule
